FILE: rtl/cau_pkg.sv
// shared widths, constants, tables and types of the complex arithmetic unit
// no dependencies
package cau_pkg;

   localparam int DATA_WIDTH    = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int FRAC_BITS     = DATA_WIDTH - 4;
   localparam int GUARD         = 8;

   // cordic datapath widths: x and y carry guard bits plus growth headroom
   localparam int ROT_W = DATA_WIDTH + GUARD + 3;
   localparam int ANG_W = 34;
   localparam int IDX_W = $clog2(CORDIC_STAGES);

   // depth of the atan table and the index width it needs
   localparam int ATAN_N     = 32;
   localparam int ATAN_IDX_W = $clog2(ATAN_N);

   // gain correction and final rounding
   localparam int GAIN_W     = 21;
   localparam int GAIN_SHIFT = 20 + GUARD;
   localparam int ANG_SHIFT  = 30 - FRAC_BITS;
   localparam int MAG_W      = ROT_W + GAIN_W;
   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int RES_W      = 2 * DATA_WIDTH + 2;

   localparam logic signed [GAIN_W-1:0] GAIN_Q20    = 21'sd636752;
   localparam logic signed [ANG_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;

   // atan(2^-i) in q3.30 radians
   localparam logic signed [ANG_W-1:0] ATAN_Q30 [ATAN_N] = '{
      34'sd843314857, 34'sd497837830, 34'sd263043837, 34'sd133525159,
      34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
      34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
      34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
      34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
      34'sd1024,      34'sd512,       34'sd256,       34'sd128,
      34'sd64,        34'sd32,        34'sd16,        34'sd8,
      34'sd4,         34'sd2,         34'sd1,         34'sd1
   };

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   localparam data_type DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef enum logic [2:0] {
      MODE_ADD  = 3'd0,
      MODE_SUB  = 3'd1,
      MODE_MUL  = 3'd2,
      MODE_MAG  = 3'd3,
      MODE_ANG  = 3'd4,
      MODE_CONJ = 3'd5
   } mode_type;

   // operands and opcode riding alongside the cordic chain
   typedef struct packed {
      mode_type mode;
      logic     zero;
      data_type a_re;
      data_type a_im;
      data_type b_re;
      data_type b_im;
   } side_type;

   // cordic vector and accumulated angle
   typedef struct packed {
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
      logic signed [ANG_W-1:0] z;
   } rot_type;

endpackage

FILE: rtl/cau_if.sv
// request and response channel interfaces of the complex arithmetic unit
// depends on cau_pkg
interface cau_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         mode;
   cau_pkg::data_type  a_re;
   cau_pkg::data_type  a_im;
   cau_pkg::data_type  b_re;
   cau_pkg::data_type  b_im;

   modport source (output valid, mode, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, mode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
   logic               valid;
   logic               ready;
   cau_pkg::data_type  res_re;
   cau_pkg::data_type  res_im;
   logic               saturated;

   modport source (output valid, res_re, res_im, saturated, input ready);
   modport sink   (input valid, res_re, res_im, saturated, output ready);
endinterface

FILE: rtl/cau_front.sv
// input stage: registers a transaction and pre-rotates operand a into the right half plane
// depends on cau_pkg
module cau_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [2:0]        mode,
   input  cau_pkg::data_type a_re,
   input  cau_pkg::data_type a_im,
   input  cau_pkg::data_type b_re,
   input  cau_pkg::data_type b_im,
   output logic              out_valid,
   input  logic              out_ready,
   output cau_pkg::rot_type  out_rot,
   output cau_pkg::side_type out_side
);
   localparam int RW = cau_pkg::ROT_W;

   logic              valid_ff, valid_in;
   cau_pkg::rot_type  rot_ff, rot_in;
   cau_pkg::side_type side_ff, side_in;
   logic signed [RW-1:0] xg, yg;

   always_comb begin
      xg = RW'(a_re) <<< cau_pkg::GUARD;
      yg = RW'(a_im) <<< cau_pkg::GUARD;
      rot_in.x = xg;
      rot_in.y = yg;
      rot_in.z = '0;
      // left half plane: rotate by a quarter turn first
      if (xg[RW-1]) begin
         if (!yg[RW-1]) begin
            rot_in.x = yg;
            rot_in.y = -xg;
            rot_in.z = cau_pkg::HALF_PI_Q30;
         end else begin
            rot_in.x = -yg;
            rot_in.y = xg;
            rot_in.z = -cau_pkg::HALF_PI_Q30;
         end
      end
      side_in.mode = cau_pkg::mode_type'(mode);
      side_in.zero = (a_re == '0) && (a_im == '0);
      side_in.a_re = a_re;
      side_in.a_im = a_im;
      side_in.b_re = b_re;
      side_in.b_im = b_im;
      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         rot_ff  <= rot_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rot   = rot_ff;
   assign out_side  = side_ff;

endmodule

FILE: rtl/cau_cell.sv
// one cordic vectoring step, registered, with the operand sideband passed along
// depends on cau_pkg
module cau_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [cau_pkg::IDX_W-1:0]  stage_idx,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  cau_pkg::rot_type           in_rot,
   input  cau_pkg::side_type          in_side,
   output logic                       out_valid,
   input  logic                       out_ready,
   output cau_pkg::rot_type           out_rot,
   output cau_pkg::side_type          out_side
);
   localparam int RW = cau_pkg::ROT_W;
   localparam int AW = cau_pkg::ATAN_IDX_W;

   logic              valid_ff, valid_in;
   cau_pkg::rot_type  rot_ff, rot_in;
   cau_pkg::side_type side_ff;
   logic signed [RW-1:0] xs, ys;
   logic signed [cau_pkg::ANG_W-1:0] atan_step;
   logic [AW-1:0]     atan_idx;

   always_comb begin
      xs = in_rot.x >>> stage_idx;
      ys = in_rot.y >>> stage_idx;
      atan_idx  = AW'(stage_idx);
      atan_step = cau_pkg::ATAN_Q30[atan_idx];
      // drive y toward zero
      if (!in_rot.y[RW-1]) begin
         rot_in.x = in_rot.x + ys;
         rot_in.y = in_rot.y - xs;
         rot_in.z = in_rot.z + atan_step;
      end else begin
         rot_in.x = in_rot.x - ys;
         rot_in.y = in_rot.y + xs;
         rot_in.z = in_rot.z - atan_step;
      end
      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         rot_ff  <= rot_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rot   = rot_ff;
   assign out_side  = side_ff;

endmodule

FILE: rtl/cau_back.sv
// result stages: products and gain correction, then rounding, selection and saturation
// depends on cau_pkg
module cau_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cau_pkg::rot_type  in_rot,
   input  cau_pkg::side_type in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output cau_pkg::data_type res_re,
   output cau_pkg::data_type res_im,
   output logic              saturated
);
   localparam int DW = cau_pkg::DATA_WIDTH;
   localparam int RW = cau_pkg::RES_W;
   localparam int MW = cau_pkg::MAG_W;
   localparam int ZW = cau_pkg::ANG_W;
   localparam int PW = cau_pkg::PROD_W;

   localparam logic signed [RW-1:0] MUL_HALF =
      {{(RW-1){1'b0}}, 1'b1} << (cau_pkg::FRAC_BITS - 1);
   localparam logic signed [MW-1:0] MAG_HALF =
      {{(MW-1){1'b0}}, 1'b1} << (cau_pkg::GAIN_SHIFT - 1);
   localparam logic signed [ZW-1:0] ANG_HALF =
      {{(ZW-1){1'b0}}, 1'b1} << (cau_pkg::ANG_SHIFT - 1);

   // product stage
   logic                 v1_ff, v1_in, ready1, ready2;
   cau_pkg::side_type    side1_ff;
   logic signed [MW-1:0] mag_ff, mag_in;
   logic signed [ZW-1:0] z_ff;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [PW-1:0] p_rr_in, p_ii_in, p_ri_in, p_ir_in;

   // output stage
   logic                 out_valid_ff, out_valid_in;
   cau_pkg::data_type    res_re_ff, res_re_in, res_im_ff, res_im_in;
   logic                 sat_ff, sat_in;
   logic signed [RW-1:0] re_w, im_w;
   logic signed [MW-1:0] mag_r;
   logic signed [ZW-1:0] ang_r;
   logic                 sat_re, sat_im;

   always_comb begin
      mag_in  = in_rot.x * cau_pkg::GAIN_Q20;
      p_rr_in = in_side.a_re * in_side.b_re;
      p_ii_in = in_side.a_im * in_side.b_im;
      p_ri_in = in_side.a_re * in_side.b_im;
      p_ir_in = in_side.a_im * in_side.b_re;
      ready2       = !out_valid_ff || out_ready;
      ready1       = !v1_ff || ready2;
      v1_in        = ready1 ? in_valid : v1_ff;
      out_valid_in = ready2 ? v1_ff : out_valid_ff;
   end

   always_comb begin
      mag_r = (mag_ff + MAG_HALF) >>> cau_pkg::GAIN_SHIFT;
      ang_r = (z_ff + ANG_HALF) >>> cau_pkg::ANG_SHIFT;
      re_w  = '0;
      im_w  = '0;
      case (side1_ff.mode)
         cau_pkg::MODE_ADD: begin
            re_w = RW'(side1_ff.a_re) + RW'(side1_ff.b_re);
            im_w = RW'(side1_ff.a_im) + RW'(side1_ff.b_im);
         end
         cau_pkg::MODE_SUB: begin
            re_w = RW'(side1_ff.a_re) - RW'(side1_ff.b_re);
            im_w = RW'(side1_ff.a_im) - RW'(side1_ff.b_im);
         end
         cau_pkg::MODE_MUL: begin
            re_w = (RW'(p_rr_ff) - RW'(p_ii_ff) + MUL_HALF) >>> cau_pkg::FRAC_BITS;
            im_w = (RW'(p_ri_ff) + RW'(p_ir_ff) + MUL_HALF) >>> cau_pkg::FRAC_BITS;
         end
         cau_pkg::MODE_MAG: begin
            re_w = side1_ff.zero ? '0 : RW'(mag_r);
         end
         cau_pkg::MODE_ANG: begin
            re_w = side1_ff.zero ? '0 : RW'(ang_r);
         end
         cau_pkg::MODE_CONJ: begin
            re_w = RW'(side1_ff.a_re);
            im_w = -RW'(side1_ff.a_im);
         end
         default: begin
            re_w = '0;
            im_w = '0;
         end
      endcase
      // in range when the sign bit and all bits above it agree
      sat_re = !((&re_w[RW-1:DW-1]) || !(|re_w[RW-1:DW-1]));
      sat_im = !((&im_w[RW-1:DW-1]) || !(|im_w[RW-1:DW-1]));
      if (sat_re) begin
         res_re_in = re_w[RW-1] ? cau_pkg::DATA_MIN : cau_pkg::DATA_MAX;
      end else begin
         res_re_in = re_w[DW-1:0];
      end
      if (sat_im) begin
         res_im_in = im_w[RW-1] ? cau_pkg::DATA_MIN : cau_pkg::DATA_MAX;
      end else begin
         res_im_in = im_w[DW-1:0];
      end
      sat_in = sat_re || sat_im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         out_valid_ff <= out_valid_in;
      end
      if (in_valid && ready1) begin
         side1_ff <= in_side;
         mag_ff   <= mag_in;
         z_ff     <= in_rot.z;
         p_rr_ff  <= p_rr_in;
         p_ii_ff  <= p_ii_in;
         p_ri_ff  <= p_ri_in;
         p_ir_ff  <= p_ir_in;
      end
      if (v1_ff && ready2) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         sat_ff    <= sat_in;
      end
   end

   assign in_ready  = ready1;
   assign out_valid = out_valid_ff;
   assign res_re    = res_re_ff;
   assign res_im    = res_im_ff;
   assign saturated = sat_ff;

`ifndef SYNTH
   // a result only appears after the product stage held a transaction
   a_out_from_stage1: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(v1_ff))
      else $error("result valid without a transaction in the product stage");
`endif

endmodule

FILE: rtl/complex_arithmetic_unit.sv
// complex arithmetic unit top level: input stage, cordic chain and result stages
// depends on cau_pkg, cau_if, cau_front, cau_cell, cau_back
//
// usage
//   req_ch carries one transaction per operation: mode plus operands a and b
//   (signed q3.12); rsp_ch returns one transaction with res_re, res_im and
//   the saturated flag. add, subtract, multiply, magnitude, angle and
//   conjugate share one pipeline, so results leave in request order.
// pipeline and throughput
//   every transaction passes 1 + CORDIC_STAGES + 2 registers; one transaction
//   per cycle is accepted when rsp_ch is not stalled. the length is set by
//   the cordic chain, one cell per micro-rotation, followed by a product
//   stage and the rounding/saturation stage.
// reset
//   synchronous reset clears every valid bit; pipeline data is not cleared.
// stall
//   each stage holds its transaction only while the one after it is full and
//   stalled, so a stalled receiver first fills the bubbles in the chain and
//   req_ch.ready drops only once the whole chain is full.
module complex_arithmetic_unit (
   input  logic      clock,
   input  logic      reset,
   cau_req_if.sink   req_ch,
   cau_rsp_if.source rsp_ch
);
   localparam int NS = cau_pkg::CORDIC_STAGES;
   localparam int IW = cau_pkg::IDX_W;

   // chain links: index 0 is the input stage output, NS the last cell output
   logic              link_valid [NS+1];
   logic              link_ready [NS+1];
   cau_pkg::rot_type  link_rot   [NS+1];
   cau_pkg::side_type link_side  [NS+1];

   // input stage with quadrant pre-rotation
   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .mode      (req_ch.mode),
      .a_re      (req_ch.a_re),
      .a_im      (req_ch.a_im),
      .b_re      (req_ch.b_re),
      .b_im      (req_ch.b_im),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_rot   (link_rot[0]),
      .out_side  (link_side[0])
   );

   // one cordic cell per micro-rotation, shift and atan set by position
   for (genvar i = 0; i < NS; i++) begin : g_cell
      cau_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (IW'(i)),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_rot    (link_rot[i]),
         .in_side   (link_side[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_rot   (link_rot[i+1]),
         .out_side  (link_side[i+1])
      );
   end

   // gain correction, products, rounding and saturation
   cau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[NS]),
      .in_ready  (link_ready[NS]),
      .in_rot    (link_rot[NS]),
      .in_side   (link_side[NS]),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .res_re    (rsp_ch.res_re),
      .res_im    (rsp_ch.res_im),
      .saturated (rsp_ch.saturated)
   );

`ifndef SYNTH
   // back pressure reaches the input only from a stalled response
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (rsp_ch.valid && !rsp_ch.ready))
      else $error("input stalled while the response side is free");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid right after reset");

   // a saturated result carries a clipped part
   a_sat_clipped: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.saturated) |->
         (rsp_ch.res_re == cau_pkg::DATA_MAX || rsp_ch.res_re == cau_pkg::DATA_MIN ||
          rsp_ch.res_im == cau_pkg::DATA_MAX || rsp_ch.res_im == cau_pkg::DATA_MIN))
      else $error("saturated flag without a clipped result part");
`endif

endmodule
